// ===== rtl/core/palmprint_direction_coder_defines.svh =====
// Assertion macros for the direction coder RTL (used by pdc_packer).
// Each expects clk and arst_n in scope.
`ifndef PALMPRINT_DIRECTION_CODER_DEFINES_SVH
`define PALMPRINT_DIRECTION_CODER_DEFINES_SVH

// Same-cycle implication.
`define PDC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PDC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/pdc_pkg.sv =====
`timescale 1ns / 1ps

package pdc_pkg;

	localparam int MAX_DIRS   = 8;
	localparam int RESP_W     = 16;
	localparam int DIR_W      = 3;
	localparam int CFG_W      = 4;
	localparam int CNT_W      = 2;
	localparam int NIB_W      = 4;

	localparam logic [CFG_W-1:0] DIRS_RESET = 4'd6;
	localparam logic [CFG_W-1:0] DIRS_MIN   = 4'd2;
	localparam logic [CFG_W-1:0] DIRS_MAX   = 4'd8;
	localparam logic [CNT_W-1:0] CNT_FULL   = 2'd3;

	typedef logic [MAX_DIRS-1:0][RESP_W-1:0] resp_arr_t;

	// One slot of the argmax chain.
	typedef struct packed {
		logic             valid;
		logic [DIR_W-1:0] best;
		logic [RESP_W-1:0] best_val;
		resp_arr_t        resp;
		logic             last;
	} pdc_stage_t;

endpackage

// ===== rtl/core/pdc_cell.sv =====
`timescale 1ns / 1ps

// One argmax cell: checks its own direction against the running best.
module pdc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [pdc_pkg::DIR_W-1:0]     idx,
	input  logic [pdc_pkg::CFG_W-1:0]     n_act,
	input  pdc_pkg::pdc_stage_t           stage_in,
	output pdc_pkg::pdc_stage_t           stage_out
);

	logic                          valid_q;
	pdc_pkg::pdc_stage_t           data_q;
	pdc_pkg::pdc_stage_t           nxt;
	logic                          take;

	// strict greater keeps the lower index on ties
	assign take = ({1'b0, idx} < n_act) && (stage_in.resp[idx] > stage_in.best_val);

	always_comb begin
		nxt = stage_in;
		if (take) begin
			nxt.best     = idx;
			nxt.best_val = stage_in.resp[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= stage_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		stage_out       = data_q;
		stage_out.valid = valid_q;
	end

endmodule

// ===== rtl/core/pdc_packer.sv =====
`timescale 1ns / 1ps

`include "palmprint_direction_coder_defines.svh"

// Side bit, nibble packing and the output register.
module pdc_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [pdc_pkg::CFG_W-1:0]     n_act,
	input  pdc_pkg::pdc_stage_t           stage_in,
	output logic                          out_valid,
	output logic [pdc_pkg::DIR_W-1:0]     direction,
	output logic                          side_bit,
	output logic [pdc_pkg::NIB_W-1:0]     packed_nibble,
	output logic                          nibble_valid,
	output logic                          end_of_image
);

	logic [pdc_pkg::NIB_W-1:0] acc_q;
	logic [pdc_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic [pdc_pkg::DIR_W-1:0] dir_q;
	logic                      side_q;
	logic [pdc_pkg::NIB_W-1:0] nib_q;
	logic                      nib_valid_q;
	logic                      eoi_q;

	logic [pdc_pkg::DIR_W-1:0] last_dir;
	logic [pdc_pkg::DIR_W-1:0] next_dir;
	logic [pdc_pkg::DIR_W-1:0] prev_dir;
	logic                      side;
	logic [pdc_pkg::NIB_W-1:0] acc_new;
	logic                      flush;
	logic                      load;

	assign last_dir = pdc_pkg::DIR_W'(n_act - 4'd1);
	assign next_dir = (stage_in.best == last_dir) ? '0 : stage_in.best + 3'd1;
	assign prev_dir = (stage_in.best == '0) ? last_dir : stage_in.best - 3'd1;
	assign side     = stage_in.resp[next_dir] >= stage_in.resp[prev_dir];

	// earliest pixel lands in bit 3
	assign acc_new = acc_q | (pdc_pkg::NIB_W'(side) << (pdc_pkg::CNT_FULL - cnt_q));
	assign flush   = (cnt_q == pdc_pkg::CNT_FULL) || stage_in.last;
	assign load    = adv && stage_in.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= stage_in.valid;
			if (stage_in.valid) begin
				if (flush) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_new;
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dir_q       <= stage_in.best;
			side_q      <= side;
			nib_q       <= flush ? acc_new : '0;
			nib_valid_q <= flush;
			eoi_q       <= stage_in.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign direction     = dir_q;
	assign side_bit      = side_q;
	assign packed_nibble = nib_q;
	assign nibble_valid  = nib_valid_q;
	assign end_of_image  = eoi_q;

	`PDC_ASSERT_NOW(a_nib_zero, out_valid_q && !nib_valid_q, nib_q == '0, "partial nibble leaked")
	`PDC_ASSERT_NEXT(a_flush_clr, load && stage_in.last, {cnt_q, acc_q} == '0, "flush did not clear")
	`PDC_ASSERT_NOW(a_dir_range, out_valid_q, {1'b0, dir_q} < n_act, "direction beyond active count")

endmodule

// ===== rtl/core/palmprint_direction_coder.sv =====
`timescale 1ns / 1ps

// Palmprint direction coder. Each transfer on the input carries one pixel's
// eight filter responses; each output transfer carries its dominant direction
// (lowest index on ties), the side bit (next direction's response >= previous,
// cyclic over the active count), and every fourth pixel or at the last pixel
// of an image a packed nibble of side bits with the earliest pixel in bit 3.
// One pixel per clock is sustained while the output is not stalled; a result
// passes seven argmax cells, one per direction above 0, then the packing/output
// register. A stall on the output freezes the whole chain.
// directions_in_use (reset 6, clamped to 2..8) may only be written while idle.
module palmprint_direction_coder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pdc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pdc_pkg::RESP_W-1:0]    response_0,
	input  logic [pdc_pkg::RESP_W-1:0]    response_1,
	input  logic [pdc_pkg::RESP_W-1:0]    response_2,
	input  logic [pdc_pkg::RESP_W-1:0]    response_3,
	input  logic [pdc_pkg::RESP_W-1:0]    response_4,
	input  logic [pdc_pkg::RESP_W-1:0]    response_5,
	input  logic [pdc_pkg::RESP_W-1:0]    response_6,
	input  logic [pdc_pkg::RESP_W-1:0]    response_7,
	input  logic                          last_pixel,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pdc_pkg::DIR_W-1:0]     direction,
	output logic                          side_bit,
	output logic [pdc_pkg::NIB_W-1:0]     packed_nibble,
	output logic                          nibble_valid,
	output logic                          end_of_image
);

	logic [pdc_pkg::CFG_W-1:0] dirs_q;
	logic [pdc_pkg::CFG_W-1:0] n_act;
	logic                      adv;

	pdc_pkg::pdc_stage_t st [pdc_pkg::MAX_DIRS];

	// direction count register, clamped on use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirs_q <= pdc_pkg::DIRS_RESET;
		end else if (cfg_we) begin
			dirs_q <= cfg_wdata;
		end
	end

	always_comb begin
		n_act = dirs_q;
		if (dirs_q < pdc_pkg::DIRS_MIN) begin
			n_act = pdc_pkg::DIRS_MIN;
		end else if (dirs_q > pdc_pkg::DIRS_MAX) begin
			n_act = pdc_pkg::DIRS_MAX;
		end
	end

	// chain moves unless a finished result is held by the sink
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// head of the chain: direction 0 is the initial best
	always_comb begin
		st[0].valid    = in_valid;
		st[0].resp[0]  = response_0;
		st[0].resp[1]  = response_1;
		st[0].resp[2]  = response_2;
		st[0].resp[3]  = response_3;
		st[0].resp[4]  = response_4;
		st[0].resp[5]  = response_5;
		st[0].resp[6]  = response_6;
		st[0].resp[7]  = response_7;
		st[0].best     = '0;
		st[0].best_val = response_0;
		st[0].last     = last_pixel;
	end

	for (genvar d = 1; d < pdc_pkg::MAX_DIRS; d++) begin : g_cell
		pdc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.idx       (pdc_pkg::DIR_W'(d)),
			.n_act     (n_act),
			.stage_in  (st[d-1]),
			.stage_out (st[d])
		);
	end

	pdc_packer u_packer (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.n_act         (n_act),
		.stage_in      (st[pdc_pkg::MAX_DIRS-1]),
		.out_valid     (out_valid),
		.direction     (direction),
		.side_bit      (side_bit),
		.packed_nibble (packed_nibble),
		.nibble_valid  (nibble_valid),
		.end_of_image  (end_of_image)
	);

endmodule

// ===== test/palmprint_direction_coder_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the direction coder: pixels are queued by the
// stimulus process, presented by a clocked driver, predicted on each accepted
// transfer and compared on each output transfer.
module palmprint_direction_coder_tb;

	// One pixel as presented on the input channel.
	typedef struct packed {
		pdc_pkg::resp_arr_t resp;
		logic               eoi;
	} pixel_t;

	// One coded pixel as expected on the output channel.
	typedef struct packed {
		logic [pdc_pkg::DIR_W-1:0] dir;
		logic                      side;
		logic [pdc_pkg::NIB_W-1:0] nib;
		logic                      nib_ok;
		logic                      eoi;
	} coded_t;

	localparam int HOLD_CYCLES = 60;    // long receiver hold, well past the chain depth
	localparam int TAIL_CYCLES = 20;    // drain margin after the last phase
	localparam int STUCK_LIMIT = 3000;  // cycles with no transfer before giving up

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [pdc_pkg::CFG_W-1:0] cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	pixel_t                    pix_drv = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [pdc_pkg::DIR_W-1:0] direction;
	logic                      side_bit;
	logic [pdc_pkg::NIB_W-1:0] packed_nibble;
	logic                      nibble_valid;
	logic                      end_of_image;

	pixel_t pix_q[$];   // pixels waiting for the driver
	coded_t code_q[$];  // coded pixels waiting for the output channel

	// Predictor state: its own copy of the register and the nibble packer.
	logic [pdc_pkg::CFG_W-1:0] dirs_cfg = pdc_pkg::DIRS_RESET;
	logic [pdc_pkg::NIB_W-1:0] nib_acc = '0;
	logic [pdc_pkg::CNT_W-1:0] nib_fill = '0;

	int err_count = 0;
	int tx_mode = 0;        // 0: back to back, 1: light gaps, 2: heavy gaps
	int rx_mode = 0;        // same scale for output stalls
	int hold_req = 0;       // bumped by the stimulus to ask for one long hold
	int pix_in_count = 0;   // input transfers seen at the rising edge
	int stuck_cycles = 0;

	always #2 clk = ~clk;

	palmprint_direction_coder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.response_0   (pix_drv.resp[0]),
		.response_1   (pix_drv.resp[1]),
		.response_2   (pix_drv.resp[2]),
		.response_3   (pix_drv.resp[3]),
		.response_4   (pix_drv.resp[4]),
		.response_5   (pix_drv.resp[5]),
		.response_6   (pix_drv.resp[6]),
		.response_7   (pix_drv.resp[7]),
		.last_pixel   (pix_drv.eoi),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.direction    (direction),
		.side_bit     (side_bit),
		.packed_nibble(packed_nibble),
		.nibble_valid (nibble_valid),
		.end_of_image (end_of_image)
	);

	// Queue helpers: append at the tail.
	function automatic void queue_pixel(pixel_t px);
		pix_q = {pix_q, px};
	endfunction

	function automatic void queue_code(coded_t c);
		code_q = {code_q, c};
	endfunction

	// Length of the next gap or stall: mostly none or short, now and then long.
	function automatic int pick_len(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0)
			return 0;
		if (r < ((mode == 1) ? 65 : 35))
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Codes one pixel: argmax over the active directions (first index wins
	// a tie), side bit from the cyclic neighbors, then the nibble packer.
	function automatic coded_t code_pixel(pixel_t px);
		coded_t c;
		int     n;
		int     best;
		int     nxt;
		int     prv;
		// Register values outside 2..8 are clamped
		if (dirs_cfg < pdc_pkg::DIRS_MIN)
			n = int'(pdc_pkg::DIRS_MIN);
		else if (dirs_cfg > pdc_pkg::DIRS_MAX)
			n = int'(pdc_pkg::DIRS_MAX);
		else
			n = int'(dirs_cfg);
		best = 0;
		for (int d = 1; d < n; d++)
			if (px.resp[d] > px.resp[best])
				best = d;
		nxt = (best == n - 1) ? 0 : best + 1;
		prv = (best == 0) ? n - 1 : best - 1;
		c.dir = best[pdc_pkg::DIR_W-1:0];
		c.side = (px.resp[nxt] >= px.resp[prv]);
		c.eoi = px.eoi;
		// earliest pixel lands in the top bit
		nib_acc[pdc_pkg::NIB_W - 1 - int'(nib_fill)] = c.side;
		if (nib_fill == pdc_pkg::CNT_FULL || px.eoi) begin
			// full nibble, or flush of a partial one zero-padded
			c.nib_ok = 1'b1;
			c.nib = nib_acc;
			nib_acc = '0;
			nib_fill = '0;
		end else begin
			c.nib_ok = 1'b0;
			c.nib = '0;
			nib_fill = nib_fill + 1'b1;
		end
		return c;
	endfunction

	// Random pixel content; several flavors so ties and equal neighbors
	// come up often, not just wide random values.
	function automatic pixel_t make_pixel(logic eoi);
		pixel_t px;
		int     hot;
		logic [pdc_pkg::RESP_W-1:0] corner[4];
		corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
		hot = $urandom_range(0, pdc_pkg::MAX_DIRS - 1);
		px.eoi = eoi;
		case ($urandom_range(0, 3))
			0: begin
				for (int d = 0; d < pdc_pkg::MAX_DIRS; d++)
					px.resp[d] = pdc_pkg::RESP_W'($urandom_range(0, 65535));
			end
			1: begin
				for (int d = 0; d < pdc_pkg::MAX_DIRS; d++)
					px.resp[d] = corner[$urandom_range(0, 3)];
			end
			2: begin
				// tiny range: many exact ties
				for (int d = 0; d < pdc_pkg::MAX_DIRS; d++)
					px.resp[d] = pdc_pkg::RESP_W'($urandom_range(0, 3));
			end
			default: begin
				for (int d = 0; d < pdc_pkg::MAX_DIRS; d++)
					px.resp[d] = pdc_pkg::RESP_W'($urandom_range(0, 16'h3FFF));
				px.resp[hot] = pdc_pkg::RESP_W'($urandom_range(16'hC000, 16'hFFFF));
			end
		endcase
		return px;
	endfunction

	// One image: a run of pixels with the end marker on the last one.
	task automatic push_image(int len);
		for (int k = 0; k < len; k++)
			queue_pixel(make_pixel(k == len - 1));
	endtask

	// Random images adding up to about n pixels. A few very long runs keep
	// the packer cycling many nibbles without a flush.
	task automatic push_images(int n);
		int len;
		while (n > 0) begin
			if ($urandom_range(0, 19) == 0)
				len = $urandom_range(20, 40);
			else
				len = $urandom_range(1, 10);
			push_image(len);
			n -= len;
		end
	endtask

	// Sender pause: everything queued is sent and every result is back.
	task automatic wait_idle();
		while (pix_q.size() != 0 || in_valid || code_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Register write; only called with the pipe empty.
	task automatic write_dirs(logic [pdc_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		dirs_cfg = val;
	endtask

	// Input driver. A new pixel (or a gap) is chosen only when the current
	// transfer has been taken, so a stalled payload holds still.
	int drv_seen = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!in_valid || pix_in_count != drv_seen) begin
			drv_seen = pix_in_count;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pix_q.size() != 0) begin
				pix_drv <= pix_q.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_len(tx_mode);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output stall driver; a requested hold is counted here.
	int hold_seen = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			stall_left = pick_len(rx_mode);
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	// Input side: every accepted pixel is coded right away.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			queue_code(code_pixel(pix_drv));
			pix_in_count++;
		end
	end

	// Output side: each transfer against the oldest expectation.
	always @(posedge clk) begin
		coded_t want;
		if (out_valid && !out_stall) begin
			if (code_q.size() == 0) begin
				$error("result transfer with no pixel outstanding");
				err_count++;
			end else begin
				want = code_q.pop_front();
				if (direction !== want.dir) begin
					$error("direction: expected %0d, got %0d", want.dir, direction);
					err_count++;
				end
				if (side_bit !== want.side) begin
					$error("side_bit: expected %0d, got %0d", want.side, side_bit);
					err_count++;
				end
				if (packed_nibble !== want.nib) begin
					$error("packed_nibble: expected %h, got %h", want.nib, packed_nibble);
					err_count++;
				end
				if (nibble_valid !== want.nib_ok) begin
					$error("nibble_valid: expected %0d, got %0d", want.nib_ok,
						nibble_valid);
					err_count++;
				end
				if (end_of_image !== want.eoi) begin
					$error("end_of_image: expected %0d, got %0d", want.eoi, end_of_image);
					err_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("palmprint_direction_coder_tb: done, errors");
			$finish;
		end
	end

	// Stimulus: directed pixels at the reset setting, then random phases,
	// each at a new directions_in_use value (clamped ones included).
	initial begin
		pixel_t px;
		logic [pdc_pkg::CFG_W-1:0] dirs_seq[11];
		dirs_seq = '{4'd8, 4'd2, 4'd0, 4'd1, 4'd15, 4'd9, 4'd3, 4'd4, 4'd5, 4'd7, 4'd8};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed, reset value of 6 directions. One strong direction per
		// index; indexes 6 and 7 are beyond the count and must be ignored.
		// End marker on the fourth pixel: full nibble and flush together.
		for (int i = 0; i < pdc_pkg::MAX_DIRS; i++) begin
			for (int d = 0; d < pdc_pkg::MAX_DIRS; d++)
				px.resp[d] = 16'h1000 + 16'(d);
			px.resp[i] = 16'hFFFF;
			px.eoi = (i == 3);
			queue_pixel(px);
		end
		// all zero: every compare ties, direction 0, side set
		px.resp = '0;
		px.eoi = 1'b0;
		queue_pixel(px);
		// all full scale
		px.resp = '1;
		queue_pixel(px);
		// two equal maxima: lower index wins
		px.resp = '0;
		px.resp[2] = 16'hFFFF;
		px.resp[4] = 16'hFFFF;
		queue_pixel(px);
		// previous neighbor larger than next: side clear, image ends on a full nibble
		px.resp = '0;
		px.resp[1] = 16'h8000;
		px.resp[0] = 16'h0001;
		px.resp[2] = 16'h0000;
		px.eoi = 1'b1;
		queue_pixel(px);
		// single-pixel image: flush with one bit
		px.resp = '1;
		queue_pixel(px);
		// max in the top active slot wraps next to direction 0
		px.resp = '0;
		px.resp[5] = 16'hFFFF;
		px.resp[4] = 16'h0002;
		px.resp[0] = 16'h0001;
		px.eoi = 1'b0;
		queue_pixel(px);
		// max at 0 wraps previous to direction 5
		px.resp = '0;
		px.resp[0] = 16'hFFFF;
		px.resp[5] = 16'h0003;
		px.resp[1] = 16'h0003;
		px.eoi = 1'b1;
		queue_pixel(px);
		wait_idle();

		for (int p = 0; p < 11; p++) begin
			write_dirs(dirs_seq[p]);
			tx_mode = p % 3;
			rx_mode = (p + 1) % 3;
			if (p == 4) begin
				// Pressure: sender offers back to back, receiver holds long
				// enough to fill the chain and push the stall to the input.
				tx_mode = 0;
				rx_mode = 0;
				push_images(80);
				while (!in_valid)
					@(posedge clk);
				repeat (5) @(posedge clk);
				hold_req++;
			end else if (p % 2 == 1) begin
				// Mid-phase pause until every result is back.
				push_images(40);
				wait_idle();
				push_images(40);
			end else begin
				push_images(80);
			end
			wait_idle();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (code_q.size() != 0) begin
			$error("%0d results never arrived", code_q.size());
			err_count++;
		end
		if (err_count == 0)
			$display("palmprint_direction_coder_tb: done, clean");
		else
			$display("palmprint_direction_coder_tb: done, errors");
		$finish;
	end

endmodule

// ===== palmprint_direction_coder.f =====
+incdir+rtl/core
rtl/core/pdc_pkg.sv
rtl/core/pdc_cell.sv
rtl/core/pdc_packer.sv
rtl/core/palmprint_direction_coder.sv
test/palmprint_direction_coder_tb.sv
